[rtl/uidq_pkg.sv]
// ============================================================================
// uidq_pkg
// Types and codes shared by the duplicate-rejecting identifier queue.
// ============================================================================
package uidq_pkg;

  // Operation codes carried in func
  localparam logic [2:0] FUNC_ENQ   = 3'd0;
  localparam logic [2:0] FUNC_DEQ   = 3'd1;
  localparam logic [2:0] FUNC_LIST  = 3'd2;
  localparam logic [2:0] FUNC_DRAIN = 3'd3;
  localparam logic [2:0] FUNC_CLOSE = 3'd4;

  // Result status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_DUP     = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_EMPTY   = 3'd3;
  localparam logic [2:0] STAT_DROPPED = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] ident;
  } uidq_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_ident;
    logic        last;
  } uidq_res_t;

  // One result offered by the sequencer to the output register
  typedef struct packed {
    logic      vld;
    uidq_res_t res;
  } uidq_emit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WALK,
    ST_RESP
  } uidq_state_t;

endpackage

[rtl/uidq_mem.sv]
// ============================================================================
// uidq_mem
// Slot memory: one write port, one read port, registered read data.
// ============================================================================
module uidq_mem #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PW          = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [PW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [PW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [QUEUE_DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/uidq_ctrl.sv]
// ============================================================================
// uidq_ctrl
// Sequencer: pointers, fill count, duplicate search and dequeue/list/drain walk.
// ============================================================================
module uidq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PW          = 4,
  parameter int CW          = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  uidq_pkg::uidq_in_t   in_data,
  output logic                 busy,
  input  logic                 out_free,
  output uidq_pkg::uidq_emit_t emit,
  output logic                 mem_re,
  output logic [PW-1:0]        mem_raddr,
  input  logic [15:0]          mem_rdata,
  output logic                 mem_we,
  output logic [PW-1:0]        mem_waddr,
  output logic [15:0]          mem_wdata
);
  import uidq_pkg::*;

  uidq_state_t   state_r, state_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [15:0]   ident_r, ident_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic          pend_r, pend_nxt;
  logic          found_r, found_nxt;
  logic [2:0]    resp_r, resp_nxt;
  logic          acc;
  logic          issue;
  logic          walk_emit;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign busy      = (state_r != ST_IDLE);
  assign acc       = in_valid && !busy;
  assign walk_emit = pend_r && out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_data.func)
            FUNC_ENQ:                        state_nxt = ST_SEARCH;
            FUNC_DEQ, FUNC_LIST, FUNC_DRAIN: state_nxt = (fill_r == '0) ? ST_RESP : ST_WALK;
            FUNC_CLOSE:                      state_nxt = ST_RESP;
            default:                         state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (left_r == '0 && !pend_r) state_nxt = ST_RESP;
      end
      ST_WALK: begin
        if (walk_emit && left_r == '0) state_nxt = ST_IDLE;
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    func_nxt   = func_r;
    ident_nxt  = ident_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    rd_ptr_nxt = rd_ptr_r;
    left_nxt   = left_r;
    pend_nxt   = 1'b0;
    found_nxt  = found_r;
    resp_nxt   = resp_r;
    issue      = 1'b0;
    emit       = '0;
    mem_we     = 1'b0;
    mem_waddr  = tail_r;
    mem_wdata  = ident_r;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          func_nxt   = in_data.func;
          ident_nxt  = in_data.ident;
          rd_ptr_nxt = head_r;
          left_nxt   = (in_data.func == FUNC_DEQ) ? CW'(1) : fill_r;
          found_nxt  = 1'b0;
          resp_nxt   = STAT_EMPTY;
          if (in_data.func == FUNC_CLOSE) begin
            resp_nxt = (fill_r != '0) ? STAT_DROPPED : STAT_OK;
            head_nxt = '0;
            tail_nxt = '0;
            fill_nxt = '0;
          end
        end
      end
      ST_SEARCH: begin
        issue    = (left_r != '0);
        pend_nxt = issue;
        if (pend_r && mem_rdata == ident_r) found_nxt = 1'b1;
        if (left_r == '0 && !pend_r) begin
          if (found_r) begin
            resp_nxt = STAT_DUP;
          end else if (fill_r == CW'(QUEUE_DEPTH)) begin
            resp_nxt = STAT_FULL;
          end else begin
            resp_nxt = STAT_OK;
            mem_we   = 1'b1;
            tail_nxt = ptr_inc(tail_r);
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      ST_WALK: begin
        // Read ahead when nothing is pending or when the pending word leaves this cycle
        issue    = (left_r != '0) && (!pend_r || out_free);
        pend_nxt = issue || (pend_r && !out_free);
        if (walk_emit) begin
          emit.vld           = 1'b1;
          emit.res.status    = STAT_OK;
          emit.res.out_ident = mem_rdata;
          emit.res.last      = (left_r == '0);
          if (left_r == '0) begin
            if (func_r == FUNC_DEQ) begin
              head_nxt = ptr_inc(head_r);
              fill_nxt = fill_r - 1'b1;
            end else if (func_r == FUNC_DRAIN) begin
              head_nxt = '0;
              tail_nxt = '0;
              fill_nxt = '0;
            end
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          emit.vld      = 1'b1;
          emit.res.status = resp_r;
          emit.res.last = 1'b1;
        end
      end
      default: ;
    endcase

    if (issue) begin
      rd_ptr_nxt = ptr_inc(rd_ptr_r);
      left_nxt   = left_r - 1'b1;
    end
  end

  assign mem_re    = issue;
  assign mem_raddr = rd_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    ident_r  <= ident_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    left_r   <= left_nxt;
    found_r  <= found_nxt;
    resp_r   <= resp_nxt;
  end

endmodule

[rtl/unique_id_fifo_queue_unit.sv]
// ============================================================================
// unique_id_fifo_queue_unit
// Bounded FIFO of 16-bit identifiers that rejects duplicates.
// ============================================================================
// The queue holds up to QUEUE_DEPTH identifiers in a ring of synchronous
// memory with registered read data and handles one operation at a time:
// in_stall is high from the transfer of an item until its last result has
// been offered. Enqueue reads every stored entry through the single memory
// read port to look for a duplicate; list and drain emit one result per
// cycle while out_stall is low; close, and dequeue, list or drain on an
// empty queue, give a single response. A new item may transfer as soon as
// in_stall drops. With 16 entries the longest operation, without out_stall,
// is an enqueue on a full queue. Every result goes through an output
// register, so a new item may transfer while the final result still waits
// on out_stall. Unused func codes give no result. Slots are not cleared at
// reset; the pointers and fill count are.
// ============================================================================
module unique_id_fifo_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  uidq_pkg::uidq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output uidq_pkg::uidq_res_t out_data
);
  import uidq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  uidq_emit_t    emit;
  logic          busy;
  logic          out_free;
  logic          mem_re, mem_we;
  logic [PW-1:0] mem_raddr, mem_waddr;
  logic [15:0]   mem_rdata, mem_wdata;
  logic          out_valid_r, out_valid_nxt;
  uidq_res_t     out_data_r, out_data_nxt;

  // Hold new items off while the sequencer works
  assign in_stall = busy;

  // Output register frees up when empty or when its word transfers now
  assign out_free = !out_valid_r || !out_stall;

  uidq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PW         (PW),
    .CW         (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .busy     (busy),
    .out_free (out_free),
    .emit     (emit),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata)
  );

  uidq_mem #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PW         (PW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Load a new result, drop a transferred one, otherwise hold
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit.vld) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit.res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sim/uidq_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uidq_checker
// Watches both channels of the duplicate-rejecting identifier queue, keeps a
// shadow ring of the stored identifiers, predicts every result of each
// accepted operation and compares the results that leave the block in order.
// ----------------------------------------------------------------------------
module uidq_checker #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  uidq_pkg::uidq_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  uidq_pkg::uidq_res_t out_data,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen
);
  import uidq_pkg::*;

  logic [15:0] shadow_ids [DEPTH];
  int          shadow_head;
  int          shadow_tail;
  int          shadow_fill;
  uidq_res_t   expected_results [$];
  int          errors;
  int          checked;

  function automatic uidq_res_t make_res(input logic [2:0] st, input logic [15:0] id,
                                         input logic lst);
    uidq_res_t r;
    r.status    = st;
    r.out_ident = id;
    r.last      = lst;
    return r;
  endfunction

  task automatic clear_shadow();
    shadow_head = 0;
    shadow_tail = 0;
    shadow_fill = 0;
  endtask

  // Walk the ring from head; an empty ring answers with a single empty status.
  task automatic list_entries();
    int idx;
    idx = shadow_head;
    if (shadow_fill == 0) begin
      expected_results.push_back(make_res(STAT_EMPTY, 16'd0, 1'b1));
    end else begin
      for (int n = 0; n < shadow_fill; n++) begin
        expected_results.push_back(make_res(STAT_OK, shadow_ids[idx], n == shadow_fill - 1));
        idx = (idx + 1) % DEPTH;
      end
    end
  endtask

  task automatic predict_op(input uidq_in_t op);
    logic dup_hit;
    int   idx;
    dup_hit = 1'b0;
    idx     = shadow_head;
    case (op.func)
      FUNC_ENQ: begin
        for (int n = 0; n < shadow_fill; n++) begin
          if (shadow_ids[idx] == op.ident) dup_hit = 1'b1;
          idx = (idx + 1) % DEPTH;
        end
        // duplicate check wins over the full check
        if (dup_hit) begin
          expected_results.push_back(make_res(STAT_DUP, 16'd0, 1'b1));
        end else if (shadow_fill >= DEPTH) begin
          expected_results.push_back(make_res(STAT_FULL, 16'd0, 1'b1));
        end else begin
          shadow_ids[shadow_tail] = op.ident;
          shadow_tail = (shadow_tail + 1) % DEPTH;
          shadow_fill++;
          expected_results.push_back(make_res(STAT_OK, 16'd0, 1'b1));
        end
      end
      FUNC_DEQ: begin
        if (shadow_fill == 0) begin
          expected_results.push_back(make_res(STAT_EMPTY, 16'd0, 1'b1));
        end else begin
          expected_results.push_back(make_res(STAT_OK, shadow_ids[shadow_head], 1'b1));
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_fill--;
        end
      end
      FUNC_LIST: begin
        list_entries();
      end
      FUNC_DRAIN: begin
        list_entries();
        clear_shadow();
      end
      FUNC_CLOSE: begin
        expected_results.push_back(make_res((shadow_fill != 0) ? STAT_DROPPED : STAT_OK,
                                            16'd0, 1'b1));
        clear_shadow();
      end
      default: begin
        // unused codes: no result, no state change
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result %0d field %s mismatch: expected %h, got %h",
                 $realtime, checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    uidq_res_t want;
    if (!rst_n) begin
      clear_shadow();
    end else begin
      // Outputs first: a result leaving on this edge never belongs to an
      // item accepted on the same edge.
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result status %0d ident %h last %b",
                     $realtime, out_data.status, out_data.out_ident, out_data.last);
        end else begin
          want = expected_results.pop_front();
          check_field("status", 16'(want.status), 16'(out_data.status));
          check_field("out_ident", want.out_ident, out_data.out_ident);
          check_field("last", 16'(want.last), 16'(out_data.last));
        end
      end
      if (in_valid && !in_stall) predict_op(in_data);
    end
    fail_count   <= errors;
    pending      <= expected_results.size();
    results_seen <= checked;
  end

endmodule

[sim/tb_unique_id_fifo_queue_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unique_id_fifo_queue_unit
// Drives operations into the identifier queue with random gaps and result
// stalls, while uidq_checker predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_unique_id_fifo_queue_unit;
  import uidq_pkg::*;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  uidq_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  uidq_res_t out_data;

  int fail_count;
  int pending;
  int results_seen;

  // Per-code tally of accepted operations, and the count of real operations
  // (unused codes excluded) that sets the length of the random part.
  int op_tally [8];
  int op_total;
  // Set during a window of the run to drop all idling on both sides.
  bit quiet;

  unique_id_fifo_queue_unit #(.QUEUE_DEPTH(16)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  uidq_checker #(.DEPTH(16)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("Timeout with %0d results still outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver side: random stall with a chance of 29 in 100, except in the quiet window.
  always @(negedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 29);
  end

  // Present one operation at a falling edge, hold it until a transfer
  // happens, then return at the next falling edge. A random gap may come
  // first; valid only drops during a gap, so a back-to-back item keeps it high.
  task automatic send_op(input logic [2:0] f, input logic [15:0] id);
    quiet = (op_total >= 120 && op_total < 180);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 29) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_data.func  <= f;
    in_data.ident <= id;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    op_tally[f]++;
    if (f <= FUNC_CLOSE) op_total++;
  endtask

  // Push the queue to full: the first identifier comes back as a duplicate
  // while full, a fresh one is refused as full; list, then drain, close or dequeue six.
  task automatic fill_burst();
    logic [15:0] first_id;
    first_id = 16'($urandom);
    send_op(FUNC_ENQ, first_id);
    repeat (17) send_op(FUNC_ENQ, 16'($urandom));
    send_op(FUNC_ENQ, first_id);
    send_op(FUNC_ENQ, 16'($urandom));
    send_op(FUNC_LIST, 16'($urandom));
    case ($urandom_range(0, 2))
      0: send_op(FUNC_DRAIN, 16'($urandom));
      1: send_op(FUNC_CLOSE, 16'($urandom));
      default: repeat (6) send_op(FUNC_DEQ, 16'($urandom));
    endcase
  endtask

  // Mixed traffic, enqueue heavy; identifiers come half from a small pool so
  // that duplicates are frequent, half fresh over the full 16-bit range.
  task automatic mixed_burst();
    logic [15:0] id_pool [6];
    int          pick;
    foreach (id_pool[k]) id_pool[k] = 16'($urandom);
    repeat (10) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)
        send_op(FUNC_ENQ, $urandom_range(0, 1) ? id_pool[$urandom_range(0, 5)]
                                                : 16'($urandom));
      else if (pick < 68) send_op(FUNC_DEQ, 16'($urandom));
      else if (pick < 80) send_op(FUNC_LIST, 16'($urandom));
      else if (pick < 87) send_op(FUNC_DRAIN, 16'($urandom));
      else if (pick < 93) send_op(FUNC_CLOSE, 16'($urandom));
      else send_op(3'($urandom_range(5, 7)), 16'($urandom));
    end
  endtask

  initial begin
    // Hold reset, then release it at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, every operation, empty and non-empty cases.
    send_op(FUNC_ENQ, 16'h0000);
    send_op(FUNC_ENQ, 16'hFFFF);
    send_op(FUNC_ENQ, 16'hFFFF);     // duplicate
    send_op(FUNC_DEQ, 16'h0000);     // serves the zero identifier
    send_op(FUNC_LIST, 16'hFFFF);
    send_op(FUNC_DRAIN, 16'h0000);
    send_op(FUNC_DEQ, 16'hFFFF);     // empty
    send_op(FUNC_LIST, 16'h0000);    // empty
    send_op(FUNC_DRAIN, 16'hFFFF);   // empty
    send_op(FUNC_CLOSE, 16'h0000);   // close with nothing pending
    send_op(FUNC_ENQ, 16'h5AA5);
    send_op(FUNC_ENQ, 16'hA55A);
    send_op(FUNC_CLOSE, 16'hFFFF);   // close drops pending entries
    send_op(3'd5, 16'h1234);         // unused codes are ignored
    send_op(3'd6, 16'hFFFF);
    send_op(3'd7, 16'h0000);
    send_op(FUNC_DEQ, 16'h0000);     // still empty after the unused codes

    // Random bursts until enough real operations have gone in.
    while (op_total < 310) begin
      if ($urandom_range(0, 99) < 30) fill_burst();
      else mixed_burst();
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    // Let every predicted result arrive, then allow for trailing latency.
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d operations: enq %0d, deq %0d, list %0d, drain %0d, close %0d, unused %0d",
             op_total + op_tally[5] + op_tally[6] + op_tally[7], op_tally[FUNC_ENQ],
             op_tally[FUNC_DEQ], op_tally[FUNC_LIST], op_tally[FUNC_DRAIN],
             op_tally[FUNC_CLOSE], op_tally[5] + op_tally[6] + op_tally[7]);
    $display("Checked %0d result transfers, %0d mismatches, %0d still outstanding",
             results_seen, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/uidq_pkg.sv
rtl/uidq_mem.sv
rtl/uidq_ctrl.sv
rtl/unique_id_fifo_queue_unit.sv
sim/uidq_checker.sv
sim/tb_unique_id_fifo_queue_unit.sv
